// File: rtl/core/efla_pkg.sv
// Shared types, constants and helpers for the free-list heap allocator.
package efla_pkg;

	localparam int MAX_HEAP_BYTES = 65536;
	localparam int ALIGN_BYTES    = 8;
	localparam int HEAP_WORDS     = MAX_HEAP_BYTES / 4;
	localparam int ADDR_W         = $clog2(HEAP_WORDS);
	localparam int CNT_W          = ADDR_W + 1;
	localparam int BRK_W          = $clog2(MAX_HEAP_BYTES + 1);

	localparam int MIN_SPLIT   = 16;
	localparam int INIT_CHUNK  = 4096;
	localparam int PROLOGUE_BP = 8;
	localparam int FIRST_BP    = 24;
	localparam int PRO_HDR_OFF = 4;
	localparam int PRO_FTR_OFF = 16;
	localparam int EPI_OFF     = 20;

	localparam logic [31:0] PRO_TAG = 32'(MIN_SPLIT) | 32'd1;
	localparam logic [31:0] EPI_TAG = 32'd1;

	// word index adjustments
	localparam logic [ADDR_W-1:0] WA_0  = '0;
	localparam logic [ADDR_W-1:0] WA_P1 = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] WA_M1 = '1;
	localparam logic [ADDR_W-1:0] WA_M2 = ~ADDR_W'(1);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       wdata;
	} mem_req_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_req_t;

	function automatic logic [ADDR_W-1:0] widx(input logic [31:0] off,
			input logic [ADDR_W-1:0] adj);
		return off[ADDR_W+1:2] + adj;
	endfunction

endpackage

// File: rtl/core/explicit_free_list_allocator.sv
// An allocate walks the free list first-fit; the fit is split when the rest is at least
// 16 bytes, and the heap grows when no node fits (out of memory if it cannot grow).
// A zero-size allocate answers without a heap access. A free is checked for alignment,
// range, header and footer, then rejected or taken and coalesced; a stalled output adds its wait.
// One request at a time over the single heap memory port; in_ready is high only when idle.
// On reset a clearing pass writes all 16384 heap words, then the prologue, epilogue and
// first chunk are built; in_ready stays low.
module explicit_free_list_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [15:0] request_size,
	input  logic [15:0] block_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] payload_addr,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [15:0] grow_chunk_bytes
);
	import efla_pkg::*;

	mem_req_t    mem_req;
	alu_req_t    alu_req;
	logic [31:0] mem_rdata;
	logic [32:0] alu_sum;
	logic [15:0] chunk_q;
	logic        done;
	logic        out_free;
	logic [15:0] res_addr;
	logic [1:0]  res_status;
	logic        out_valid_q;
	logic [15:0] out_addr_q;
	logic [1:0]  out_status_q;

	assign out_free     = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign payload_addr = out_addr_q;
	assign status       = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q      <= 16'(INIT_CHUNK);
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				chunk_q <= grow_chunk_bytes;
			end
			// hold the result word until taken
			if (done) begin
				out_valid_q  <= 1'b1;
				out_addr_q   <= res_addr;
				out_status_q <= res_status;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	efla_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.request_size (request_size),
		.block_addr   (block_addr),
		.chunk        (chunk_q),
		.out_free     (out_free),
		.done         (done),
		.res_addr     (res_addr),
		.res_status   (res_status),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.alu_req      (alu_req),
		.alu_sum      (alu_sum)
	);

	efla_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	efla_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

// File: rtl/core/efla_ram.sv
// Heap word memory: one port, read data registered.
module efla_ram (
	input  logic              clk,
	input  efla_pkg::mem_req_t req,
	output logic [31:0]       rdata
);
	import efla_pkg::*;

	logic [31:0] mem_q [HEAP_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
		rdata <= mem_q[req.addr];
	end

endmodule

// File: rtl/core/efla_alu.sv
// Shared 32-bit adder/subtractor with carry out used for the size math of the sequencer states.
module efla_alu (
	input  efla_pkg::alu_req_t req,
	output logic [32:0]        sum
);
	import efla_pkg::*;

	logic [32:0] b_ext;

	// with subtract, bit 32 is set when a >= b
	assign b_ext = req.sub ? {1'b0, ~req.b} : {1'b0, req.b};
	assign sum   = {1'b0, req.a} + b_ext + 33'(req.sub);

endmodule

// File: rtl/core/efla_ctrl.sv
// Sequencer: heap clear, first-fit walk, split, grow, free and coalesce.
module efla_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    operation,
	input  logic [15:0]             request_size,
	input  logic [15:0]             block_addr,
	input  logic [15:0]             chunk,
	input  logic                    out_free,
	output logic                    done,
	output logic [15:0]             res_addr,
	output logic [1:0]              res_status,
	output efla_pkg::mem_req_t      mem_req,
	input  logic [31:0]             mem_rdata,
	output efla_pkg::alu_req_t      alu_req,
	input  logic [32:0]             alu_sum
);
	import efla_pkg::*;

	typedef enum logic [5:0] {
		S_CLR, S_I0, S_I1, S_I2, S_IDLE,
		S_FF0, S_FF1, S_FF2, S_GX, S_G0, S_G1, S_G2,
		S_CV0, S_CV1, S_CV2, S_CV3, S_CV4, S_CV5, S_CV6,
		S_F0, S_F1, S_F2, S_F3, S_F4,
		S_ST0, S_ST1,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
		S_MA0, S_MA1, S_MA2, S_MA3,
		S_MB0, S_MB1, S_MB2, S_MB3, S_MB4, S_MB5,
		S_MC0, S_MC1, S_MC2, S_MC3, S_MC4, S_MC5, S_MC6, S_MC7,
		S_LI0, S_LI1, S_LI2,
		S_LO0, S_LO1, S_LO2, S_LO3,
		S_RESP
	} state_t;

	state_t state_q, sret_q, mret_q, lret_q;

	logic [31:0]      bp_q, x_q, pv_q, nx_q, sz_q, e_q, t_q, n_q, rest_q, head_q;
	logic [16:0]      asz_q;
	logic [BRK_W-1:0] brk_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      res_q;
	logic [1:0]       st_q;
	logic             na_q, alloc_q, boot_q;

	logic [31:0] mm;
	logic [16:0] asize_in;
	logic [16:0] ext;
	logic [15:0] ext_w;
	logic [16:0] grow_bytes;
	logic        free_ok_in;

	assign mm       = {mem_rdata[31:3], 3'b000};
	assign asize_in = ({1'b0, request_size} + 17'd15) & ~17'd7;
	assign ext      = (asz_q > {1'b0, chunk}) ? asz_q : {1'b0, chunk};
	assign ext_w    = {1'b0, ext[16:2]} + 16'd1;
	assign grow_bytes = {ext_w[14:1], 3'b000};
	assign free_ok_in = (block_addr[2:0] == 3'b000) && (block_addr >= 16'(FIRST_BP))
		&& ({1'b0, block_addr} < brk_q);

	assign in_ready   = (state_q == S_IDLE);
	assign done       = (state_q == S_RESP) && out_free;
	assign res_addr   = res_q;
	assign res_status = st_q;

	// shared adder operand select
	always_comb begin
		alu_req.a   = bp_q;
		alu_req.b   = sz_q;
		alu_req.sub = 1'b0;
		case (state_q)
			S_G0: alu_req.a = 32'(brk_q);
			S_M1: begin
				alu_req.b   = mm;
				alu_req.sub = 1'b1;
			end
			S_M2, S_MB4, S_CV5: alu_req.b = mm;
			S_M3: begin
				alu_req.a = pv_q;
				alu_req.b = mm;
			end
			S_MA1, S_MB1, S_MC2, S_MC3: begin
				alu_req.a = sz_q;
				alu_req.b = mm;
			end
			S_MC6: begin
				alu_req.a = nx_q;
				alu_req.b = mm;
			end
			S_FF1, S_CV1: begin
				alu_req.a   = mm;
				alu_req.b   = 32'(asz_q);
				alu_req.sub = 1'b1;
			end
			S_F1: alu_req.b = mm;
			default: ;
		endcase
	end

	// memory port
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = widx(bp_q, WA_M1);
		mem_req.wdata = sz_q;
		case (state_q)
			S_CLR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = cnt_q[ADDR_W-1:0];
				mem_req.wdata = '0;
			end
			S_I0: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(32'(PRO_HDR_OFF), WA_0);
				mem_req.wdata = PRO_TAG;
			end
			S_I1: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(32'(PRO_FTR_OFF), WA_0);
				mem_req.wdata = PRO_TAG;
			end
			S_I2: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(32'(EPI_OFF), WA_0);
				mem_req.wdata = EPI_TAG;
			end
			S_FF1:  mem_req.addr = widx(bp_q, WA_P1);
			S_M0:   mem_req.addr = widx(bp_q, WA_M2);
			S_M2, S_MB0, S_MC1: mem_req.addr = widx(pv_q, WA_M1);
			S_M3, S_MA0, S_MC2, S_MC5: mem_req.addr = widx(nx_q, WA_M1);
			S_M4, S_F2: mem_req.addr = widx(e_q, WA_M2);
			S_ST0: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = {sz_q[31:1], alloc_q};
			end
			S_ST1: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(e_q, WA_M2);
				mem_req.wdata = {sz_q[31:1], alloc_q};
			end
			S_G1: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(e_q, WA_M1);
				mem_req.wdata = EPI_TAG;
			end
			S_MA2: mem_req.we = 1'b1;
			S_MA3, S_MB5, S_MC7: begin
				mem_req.we   = 1'b1;
				mem_req.addr = widx(e_q, WA_M2);
			end
			S_MB2, S_MC4: begin
				mem_req.we   = 1'b1;
				mem_req.addr = widx(pv_q, WA_M1);
			end
			S_LI0: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(bp_q, WA_P1);
				mem_req.wdata = head_q;
			end
			S_LI1: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(head_q, WA_0);
				mem_req.wdata = bp_q;
			end
			S_LI2: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(bp_q, WA_0);
				mem_req.wdata = '0;
			end
			S_LO0: mem_req.addr = widx(x_q, WA_0);
			S_LO1: mem_req.addr = widx(x_q, WA_P1);
			S_LO2: begin
				mem_req.we    = (t_q != '0);
				mem_req.addr  = widx(t_q, WA_P1);
				mem_req.wdata = mem_rdata;
			end
			S_LO3: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = widx(n_q, WA_0);
				mem_req.wdata = t_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			sret_q  <= S_IDLE;
			mret_q  <= S_IDLE;
			lret_q  <= S_IDLE;
			bp_q    <= '0;
			x_q     <= '0;
			pv_q    <= '0;
			nx_q    <= '0;
			sz_q    <= '0;
			e_q     <= '0;
			t_q     <= '0;
			n_q     <= '0;
			rest_q  <= '0;
			head_q  <= 32'(PROLOGUE_BP);
			asz_q   <= '0;
			brk_q   <= BRK_W'(FIRST_BP);
			cnt_q   <= '0;
			res_q   <= '0;
			st_q    <= ST_OK;
			na_q    <= 1'b0;
			alloc_q <= 1'b0;
			boot_q  <= 1'b1;
		end else begin
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q[ADDR_W-1:0] == '1) begin
						state_q <= S_I0;
					end
				end
				S_I0: state_q <= S_I1;
				S_I1: state_q <= S_I2;
				S_I2: begin
					head_q  <= 32'(PROLOGUE_BP);
					brk_q   <= BRK_W'(FIRST_BP);
					sz_q    <= 32'(INIT_CHUNK);
					state_q <= S_G0;
				end
				S_IDLE: begin
					if (in_valid) begin
						res_q <= '0;
						st_q  <= ST_OK;
						if (operation == OP_ALLOC) begin
							if (request_size == '0) begin
								st_q    <= ST_ZERO;
								state_q <= S_RESP;
							end else begin
								asz_q   <= asize_in;
								bp_q    <= head_q;
								cnt_q   <= '0;
								state_q <= S_FF0;
							end
						end else begin
							bp_q    <= 32'(block_addr);
							state_q <= free_ok_in ? S_F0 : S_RESP;
						end
					end
				end
				// first-fit walk
				S_FF0: state_q <= (cnt_q == CNT_W'(HEAP_WORDS)) ? S_GX : S_FF1;
				S_FF1: begin
					if (mem_rdata[0]) begin
						state_q <= S_GX;
					end else if (alu_sum[32]) begin
						res_q   <= bp_q[15:0];
						state_q <= S_CV0;
					end else begin
						state_q <= S_FF2;
					end
				end
				S_FF2: begin
					bp_q    <= mem_rdata;
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_FF0;
				end
				// grow
				S_GX: begin
					sz_q    <= 32'(grow_bytes);
					state_q <= S_G0;
				end
				S_G0: begin
					if (alu_sum > 33'(MAX_HEAP_BYTES)) begin
						if (boot_q) begin
							boot_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							st_q    <= ST_OOM;
							res_q   <= '0;
							state_q <= S_RESP;
						end
					end else begin
						bp_q    <= 32'(brk_q);
						brk_q   <= alu_sum[BRK_W-1:0];
						alloc_q <= 1'b0;
						sret_q  <= S_G1;
						state_q <= S_ST0;
					end
				end
				S_G1: begin
					mret_q  <= S_G2;
					state_q <= S_M0;
				end
				S_G2: begin
					if (boot_q) begin
						boot_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						res_q   <= bp_q[15:0];
						state_q <= S_CV0;
					end
				end
				// carve
				S_CV0: state_q <= S_CV1;
				S_CV1: begin
					alloc_q <= 1'b1;
					state_q <= S_ST0;
					if (!alu_sum[32] || (alu_sum[31:4] == '0)) begin
						sz_q   <= mm;
						sret_q <= S_CV2;
					end else begin
						sz_q   <= 32'(asz_q);
						rest_q <= alu_sum[31:0];
						sret_q <= S_CV3;
					end
				end
				S_CV2: begin
					x_q     <= bp_q;
					lret_q  <= S_RESP;
					state_q <= S_LO0;
				end
				S_CV3: begin
					x_q     <= bp_q;
					lret_q  <= S_CV4;
					state_q <= S_LO0;
				end
				S_CV4: state_q <= S_CV5;
				S_CV5: begin
					bp_q    <= alu_sum[31:0];
					sz_q    <= rest_q;
					alloc_q <= 1'b0;
					sret_q  <= S_CV6;
					state_q <= S_ST0;
				end
				S_CV6: begin
					mret_q  <= S_RESP;
					state_q <= S_M0;
				end
				// free
				S_F0: state_q <= S_F1;
				S_F1: begin
					t_q <= mem_rdata;
					e_q <= alu_sum[31:0];
					if (mem_rdata[0] && (mem_rdata[2:1] == 2'b00) && (mem_rdata[31:4] != '0)
							&& (alu_sum <= 33'(brk_q))) begin
						state_q <= S_F2;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_F2: state_q <= S_F3;
				S_F3: begin
					if (mem_rdata == t_q) begin
						sz_q    <= {t_q[31:3], 3'b000};
						alloc_q <= 1'b0;
						sret_q  <= S_F4;
						state_q <= S_ST0;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_F4: begin
					mret_q  <= S_RESP;
					state_q <= S_M0;
				end
				// header and footer write
				S_ST0: begin
					e_q     <= alu_sum[31:0];
					state_q <= S_ST1;
				end
				S_ST1: state_q <= sret_q;
				// coalesce
				S_M0: state_q <= S_M1;
				S_M1: begin
					pv_q    <= alu_sum[31:0];
					state_q <= S_M2;
				end
				S_M2: begin
					sz_q    <= mm;
					nx_q    <= alu_sum[31:0];
					state_q <= S_M3;
				end
				S_M3: begin
					e_q     <= alu_sum[31:0];
					state_q <= S_M4;
				end
				S_M4: begin
					na_q    <= mem_rdata[0];
					state_q <= S_M5;
				end
				S_M5: begin
					if (mem_rdata[0] && na_q) begin
						state_q <= S_LI0;
					end else if (mem_rdata[0]) begin
						x_q     <= nx_q;
						lret_q  <= S_MA0;
						state_q <= S_LO0;
					end else if (na_q) begin
						x_q     <= pv_q;
						lret_q  <= S_MB0;
						state_q <= S_LO0;
					end else begin
						x_q     <= pv_q;
						lret_q  <= S_MC0;
						state_q <= S_LO0;
					end
				end
				S_MA0: state_q <= S_MA1;
				S_MA1: begin
					sz_q    <= alu_sum[31:0];
					state_q <= S_MA2;
				end
				S_MA2: begin
					e_q     <= alu_sum[31:0];
					state_q <= S_MA3;
				end
				S_MA3: state_q <= S_LI0;
				S_MB0: state_q <= S_MB1;
				S_MB1: begin
					sz_q    <= alu_sum[31:0];
					state_q <= S_MB2;
				end
				S_MB2: state_q <= S_MB3;
				S_MB3: state_q <= S_MB4;
				S_MB4: begin
					e_q     <= alu_sum[31:0];
					state_q <= S_MB5;
				end
				S_MB5: begin
					bp_q    <= pv_q;
					state_q <= S_LI0;
				end
				S_MC0: begin
					x_q     <= nx_q;
					lret_q  <= S_MC1;
					state_q <= S_LO0;
				end
				S_MC1: state_q <= S_MC2;
				S_MC2: begin
					sz_q    <= alu_sum[31:0];
					state_q <= S_MC3;
				end
				S_MC3: begin
					sz_q    <= alu_sum[31:0];
					state_q <= S_MC4;
				end
				S_MC4: state_q <= S_MC5;
				S_MC5: state_q <= S_MC6;
				S_MC6: begin
					e_q     <= alu_sum[31:0];
					state_q <= S_MC7;
				end
				S_MC7: begin
					bp_q    <= pv_q;
					state_q <= S_LI0;
				end
				// push at list head
				S_LI0: state_q <= S_LI1;
				S_LI1: state_q <= S_LI2;
				S_LI2: begin
					head_q  <= bp_q;
					state_q <= mret_q;
				end
				// unlink
				S_LO0: state_q <= S_LO1;
				S_LO1: begin
					t_q     <= mem_rdata;
					state_q <= S_LO2;
				end
				S_LO2: begin
					n_q <= mem_rdata;
					if (t_q == '0) begin
						head_q <= mem_rdata;
					end
					state_q <= S_LO3;
				end
				S_LO3: state_q <= lret_q;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_brk_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= BRK_W'(MAX_HEAP_BYTES))
		else $error("heap break beyond heap limit");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_req.we)
		else $error("memory write while idle");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after result");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HEAP_WORDS))
		else $error("walk counter overran");

endmodule
